// ===== src/cpm_pkg.sv =====
package cpm_pkg;

  // Film-fit codes of the fit_mode register.
  localparam logic [1:0] FIT_FILL  = 2'd0;
  localparam logic [1:0] FIT_HORIZ = 2'd1;
  localparam logic [1:0] FIT_VERT  = 2'd2;
  localparam logic [1:0] FIT_OVER  = 2'd3;

  // Per-item flags that ride alongside the divider operands.
  typedef struct packed {
    logic vert;       // vertical fit chosen
    logic neg_p;      // sign of the offset on the fitted axis
    logic neg_r;      // sign of the offset on the other axis
    logic lens_err;   // a lens or render input was zero
    logic depth_err;  // clip planes are equal
    logic dneg;       // far plane below near plane
  } cpm_flags_t;

  typedef struct packed {
    logic       valid;
    cpm_flags_t flags;
  } cpm_side_t;

endpackage

// ===== src/cpm_div.sv =====
module cpm_div #(
  parameter int OP_W = 94
) (
  input  logic            clk,
  input  logic            en,
  input  logic [OP_W-1:0] num,
  input  logic [OP_W-1:0] den,
  output logic [31:0]     quo,
  output logic            ovf
);

  // Restoring divider, one quotient bit per stage, most significant first.
  // The first stage also flags a quotient of 2^32 or more.
  logic [OP_W-1:0] r_s [32];
  logic [OP_W-1:0] d_s [32];
  logic [31:0]     q_s [32];
  logic            o_s [32];

  genvar k;
  for (k = 0; k < 32; k++) begin : g_stage
    logic [OP_W-1:0] r_in;
    logic [OP_W-1:0] d_in;
    logic [31:0]     q_in;
    logic            o_in;
    logic            take;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign o_in = (num >> 32) >= den;
    end else begin : g_next
      assign r_in = r_s[k-1];
      assign d_in = d_s[k-1];
      assign q_in = q_s[k-1];
      assign o_in = o_s[k-1];
    end

    assign take = (r_in >> (31 - k)) >= d_in;

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[k] <= take ? (r_in - (d_in << (31 - k))) : r_in;
        d_s[k] <= d_in;
        q_s[k] <= q_in | ({31'd0, take} << (31 - k));
        o_s[k] <= o_in;
      end
    end
  end

  assign quo = q_s[31];
  assign ovf = o_s[31];

endmodule

// ===== src/cpm_front.sv =====
module cpm_front import cpm_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int OP_W      = 94
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            item_valid,
  input  logic [25:0]     focal_mm,
  input  logic [19:0]     aperture_width,
  input  logic [19:0]     aperture_height,
  input  logic [20:0]     offset_horizontal,
  input  logic [20:0]     offset_vertical,
  input  logic [1:0]      fit_mode,
  input  logic [14:0]     render_width,
  input  logic [14:0]     render_height,
  input  logic [25:0]     near_plane,
  input  logic [35:0]     far_plane,
  input  logic [22:0]     lens_scale,
  output logic [OP_W-1:0] op_num [6],
  output logic [OP_W-1:0] op_den [6],
  output cpm_side_t       side
);

  logic v0, v1, v2, v3, v4, v5, v6, v7;

  // Stage 0: input word.
  logic [25:0] s0_f;
  logic [19:0] s0_w, s0_h;
  logic [20:0] s0_ox, s0_oy;

  // Stage 1: first products and offset magnitudes.
  logic [48:0] s1_bn;
  logic [34:0] s1_wrh, s1_rwh;
  logic [40:0] s1_fw, s1_fh;
  logic [20:0] s1_oxm, s1_oym;
  logic        s1_negx, s1_negy, s1_lz;
  logic [43:0] s1_fnl, s1_fnh;
  logic [25:0] s1_f;
  logic [19:0] s1_w, s1_h;

  // Stage 2: fit decision and operand selection.
  logic [55:0] s2_base;
  logic [19:0] s2_d;
  logic [14:0] s2_p, s2_q;
  logic [40:0] s2_fp;
  logic [20:0] s2_offp, s2_offr;
  logic [25:0] s2_f;
  logic [61:0] s2_fn;
  logic [36:0] s2_fsum;
  logic [35:0] s2_diff;
  cpm_flags_t  s2_fl;

  // Stage 3.
  logic [47:0] s3_bdl, s3_bdh;
  logic [34:0] s3_dq;
  logic [35:0] s3_offrp;
  logic [20:0] s3_offp;
  logic [19:0] s3_d;
  logic [14:0] s3_q;
  logic [40:0] s3_fp;
  logic [25:0] s3_f;
  logic [61:0] s3_fn;
  logic [36:0] s3_fsum;
  logic [35:0] s3_diff;
  cpm_flags_t  s3_fl;

  // Stage 4.
  logic [75:0] s4_bd;
  logic [34:0] s4_dq;
  logic [35:0] s4_offrp;
  logic [20:0] s4_offp;
  logic [19:0] s4_d;
  logic [14:0] s4_q;
  logic [40:0] s4_fp;
  logic [25:0] s4_f;
  logic [61:0] s4_fn;
  logic [36:0] s4_fsum;
  logic [35:0] s4_diff;
  cpm_flags_t  s4_fl;

  // Stage 5.
  logic [40:0] s5_p0, s5_p1;
  logic [38:0] s5_p2;
  logic [75:0] s5_bd;
  logic [34:0] s5_dq;
  logic [35:0] s5_offrp;
  logic [20:0] s5_offp;
  logic [19:0] s5_d;
  logic [40:0] s5_fp;
  logic [25:0] s5_f;
  logic [61:0] s5_fn;
  logic [36:0] s5_fsum;
  logic [35:0] s5_diff;
  cpm_flags_t  s5_fl;

  // Stage 6.
  logic [90:0] s6_bdq;
  logic [75:0] s6_bd;
  logic [34:0] s6_dq;
  logic [35:0] s6_offrp;
  logic [20:0] s6_offp;
  logic [19:0] s6_d;
  logic [40:0] s6_fp;
  logic [25:0] s6_f;
  logic [61:0] s6_fn;
  logic [36:0] s6_fsum;
  logic [35:0] s6_diff;
  cpm_flags_t  s6_fl;

  cpm_flags_t  s7_fl;

  logic film_wider, vert, dneg;

  assign film_wider = s1_wrh > s1_rwh;
  assign dneg       = far_plane < {10'd0, near_plane};

  always_comb begin
    case (fit_mode)
      FIT_FILL: vert = film_wider;
      FIT_VERT: vert = 1'b1;
      FIT_OVER: vert = !film_wider;
      default:  vert = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v0 <= item_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_f  <= focal_mm;
      s0_w  <= aperture_width;
      s0_h  <= aperture_height;
      s0_ox <= offset_horizontal;
      s0_oy <= offset_vertical;

      s1_bn   <= 49'(near_plane) * 49'(lens_scale);
      s1_wrh  <= 35'(s0_w) * 35'(render_height);
      s1_rwh  <= 35'(render_width) * 35'(s0_h);
      s1_fw   <= 41'(s0_f) * 41'(render_width);
      s1_fh   <= 41'(s0_f) * 41'(render_height);
      s1_negx <= s0_ox[20];
      s1_negy <= s0_oy[20];
      s1_oxm  <= s0_ox[20] ? (21'd0 - s0_ox) : s0_ox;
      s1_oym  <= s0_oy[20] ? (21'd0 - s0_oy) : s0_oy;
      s1_lz   <= (s0_f == '0) || (s0_w == '0) || (s0_h == '0) || (near_plane == '0) ||
                 (lens_scale == '0) || (render_width == '0) || (render_height == '0);
      s1_fnl  <= 44'(far_plane[17:0]) * 44'(near_plane);
      s1_fnh  <= 44'(far_plane[35:18]) * 44'(near_plane);
      s1_f    <= s0_f;
      s1_w    <= s0_w;
      s1_h    <= s0_h;

      // 127 * near * scale, the film-back inch to centimeter factor folded in.
      s2_base   <= {s1_bn, 7'd0} - {7'd0, s1_bn};
      s2_d      <= vert ? s1_h : s1_w;
      s2_p      <= vert ? render_height : render_width;
      s2_q      <= vert ? render_width : render_height;
      s2_fp     <= vert ? s1_fh : s1_fw;
      s2_offp   <= vert ? s1_oym : s1_oxm;
      s2_offr   <= vert ? s1_oxm : s1_oym;
      s2_f      <= s1_f;
      s2_fn     <= {s1_fnh, 18'd0} + 62'(s1_fnl);
      s2_fsum   <= 37'(far_plane) + 37'(near_plane);
      s2_diff   <= dneg ? (36'(near_plane) - far_plane) : (far_plane - 36'(near_plane));
      s2_fl.vert      <= vert;
      s2_fl.neg_p     <= vert ? s1_negy : s1_negx;
      s2_fl.neg_r     <= vert ? s1_negx : s1_negy;
      s2_fl.lens_err  <= s1_lz;
      s2_fl.depth_err <= far_plane == 36'(near_plane);
      s2_fl.dneg      <= dneg;

      s3_bdl   <= 48'(s2_base[27:0]) * 48'(s2_d);
      s3_bdh   <= 48'(s2_base[55:28]) * 48'(s2_d);
      s3_dq    <= 35'(s2_d) * 35'(s2_q);
      s3_offrp <= 36'(s2_offr) * 36'(s2_p);
      s3_offp  <= s2_offp;
      s3_d     <= s2_d;
      s3_q     <= s2_q;
      s3_fp    <= s2_fp;
      s3_f     <= s2_f;
      s3_fn    <= s2_fn;
      s3_fsum  <= s2_fsum;
      s3_diff  <= s2_diff;
      s3_fl    <= s2_fl;

      s4_bd    <= {s3_bdh, 28'd0} + 76'(s3_bdl);
      s4_dq    <= s3_dq;
      s4_offrp <= s3_offrp;
      s4_offp  <= s3_offp;
      s4_d     <= s3_d;
      s4_q     <= s3_q;
      s4_fp    <= s3_fp;
      s4_f     <= s3_f;
      s4_fn    <= s3_fn;
      s4_fsum  <= s3_fsum;
      s4_diff  <= s3_diff;
      s4_fl    <= s3_fl;

      s5_p0    <= 41'(s4_bd[25:0]) * 41'(s4_q);
      s5_p1    <= 41'(s4_bd[51:26]) * 41'(s4_q);
      s5_p2    <= 39'(s4_bd[75:52]) * 39'(s4_q);
      s5_bd    <= s4_bd;
      s5_dq    <= s4_dq;
      s5_offrp <= s4_offrp;
      s5_offp  <= s4_offp;
      s5_d     <= s4_d;
      s5_fp    <= s4_fp;
      s5_f     <= s4_f;
      s5_fn    <= s4_fn;
      s5_fsum  <= s4_fsum;
      s5_diff  <= s4_diff;
      s5_fl    <= s4_fl;

      s6_bdq   <= 91'(s5_p0) + 91'({s5_p1, 26'd0}) + {s5_p2, 52'd0};
      s6_bd    <= s5_bd;
      s6_dq    <= s5_dq;
      s6_offrp <= s5_offrp;
      s6_offp  <= s5_offp;
      s6_d     <= s5_d;
      s6_fp    <= s5_fp;
      s6_f     <= s5_f;
      s6_fn    <= s5_fn;
      s6_fsum  <= s5_fsum;
      s6_diff  <= s5_diff;
      s6_fl    <= s5_fl;

      // Each result is floor((2 num + den) / (2 den)), rounding half away from zero.
      op_num[0] <= (OP_W'(s6_f) << (3*FRAC_BITS + 1)) + OP_W'(s6_bd);
      op_den[0] <= OP_W'(s6_bd) << 1;
      op_num[1] <= (OP_W'(s6_fp) << (3*FRAC_BITS + 1)) + OP_W'(s6_bdq);
      op_den[1] <= OP_W'(s6_bdq) << 1;
      op_num[2] <= (OP_W'(s6_offp) << (FRAC_BITS + 2)) + OP_W'(s6_d);
      op_den[2] <= OP_W'(s6_d) << 1;
      op_num[3] <= (OP_W'(s6_offrp) << (FRAC_BITS + 2)) + OP_W'(s6_dq);
      op_den[3] <= OP_W'(s6_dq) << 1;
      op_num[4] <= (OP_W'(s6_fsum) << (FRAC_BITS + 1)) + OP_W'(s6_diff);
      op_den[4] <= OP_W'(s6_diff) << 1;
      op_num[5] <= (OP_W'(s6_fn) << 2) + OP_W'(s6_diff);
      op_den[5] <= OP_W'(s6_diff) << 1;
      s7_fl     <= s6_fl;
    end
  end

  assign side.valid = v7;
  assign side.flags = s7_fl;

endmodule

// ===== src/camera_projection_matrix_unit.sv =====
// Channel   Signals                                   Direction
// item      item_valid, item_stall, lens fields       in (item_stall out)
// result    result_valid, result_stall, matrix words  out (result_stall in)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// One word enters every cycle while item_stall is low; the path is an input register, seven
// multiply and operand stages, a 32-stage restoring divider (one quotient bit
// per stage, six dividers side by side) and the output register.
// Reset is synchronous and clears all valid bits and loads the register defaults.
// A stall on the result side while result_valid is high freezes the whole
// pipeline and raises item_stall in the same cycle, so no word is dropped or repeated.
module camera_projection_matrix_unit import cpm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               item_valid,
  output logic               item_stall,
  input  logic [25:0]        focal_mm,
  input  logic [19:0]        aperture_width,
  input  logic [19:0]        aperture_height,
  input  logic signed [20:0] offset_horizontal,
  input  logic signed [20:0] offset_vertical,

  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] x_scale,
  output logic signed [31:0] y_scale,
  output logic signed [31:0] x_shift,
  output logic signed [31:0] y_shift,
  output logic signed [31:0] depth_scale,
  output logic signed [31:0] depth_offset,
  output logic               math_error,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [35:0]        cfg_data
);

  // Operand width of the dividers: the widest numerator is the ratio term,
  // focal length times render size shifted up by three fraction widths.
  localparam int OP_W = (3*FRAC_BITS + 44 > 94) ? 3*FRAC_BITS + 44 : 94;

  localparam logic [2:0] REG_FIT    = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_NEAR   = 3'd3;
  localparam logic [2:0] REG_FAR    = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;

  // Round-half-away quotient to a saturated signed word; top bit is the error.
  function automatic logic [32:0] sat_round(input logic [31:0] q, input logic ovf,
                                            input logic neg);
    logic [32:0] res;
    if (!neg) begin
      if (ovf || q[31]) res = {1'b1, 32'h7FFF_FFFF};
      else              res = {1'b0, q};
    end else begin
      if (ovf || (q[31] && (q[30:0] != 31'd0))) res = {1'b1, 32'h8000_0000};
      else                                      res = {1'b0, 32'd0 - q};
    end
    return res;
  endfunction

  logic [1:0]  fit_mode;
  logic [14:0] render_width;
  logic [14:0] render_height;
  logic [25:0] near_plane;
  logic [35:0] far_plane;
  logic [22:0] lens_scale;

  logic            en;
  logic [OP_W-1:0] op_num [6];
  logic [OP_W-1:0] op_den [6];
  cpm_side_t       side;
  logic [31:0]     quo [6];
  logic            ovf [6];

  logic            sb_valid [32];
  cpm_flags_t      sb_flags [32];

  // The pipeline moves unless a finished word is held at the output.
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;
  assign cfg_ready  = 1'b1;

  // Registers are to be written by the user only while the pipeline is empty, so every
  // stage may read them directly; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= FIT_HORIZ;
      render_width  <= 15'd128;
      render_height <= 15'd128;
      near_plane    <= 26'd6554;
      far_plane     <= 36'd65536000;
      lens_scale    <= 23'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIT:    fit_mode      <= cfg_data[1:0];
        REG_WIDTH:  render_width  <= cfg_data[14:0];
        REG_HEIGHT: render_height <= cfg_data[14:0];
        REG_NEAR:   near_plane    <= cfg_data[25:0];
        REG_FAR:    far_plane     <= cfg_data;
        REG_SCALE:  lens_scale    <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  cpm_front #(
    .FRAC_BITS(FRAC_BITS),
    .OP_W     (OP_W)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .item_valid       (item_valid),
    .focal_mm         (focal_mm),
    .aperture_width   (aperture_width),
    .aperture_height  (aperture_height),
    .offset_horizontal(offset_horizontal),
    .offset_vertical  (offset_vertical),
    .fit_mode         (fit_mode),
    .render_width     (render_width),
    .render_height    (render_height),
    .near_plane       (near_plane),
    .far_plane        (far_plane),
    .lens_scale       (lens_scale),
    .op_num           (op_num),
    .op_den           (op_den),
    .side             (side)
  );

  // Six quotients: fitted-axis scale, other-axis scale, the two offsets in
  // the same order, then the two depth terms.
  genvar j;
  for (j = 0; j < 6; j++) begin : g_div
    cpm_div #(.OP_W(OP_W)) u_div (
      .clk(clk),
      .en (en),
      .num(op_num[j]),
      .den(op_den[j]),
      .quo(quo[j]),
      .ovf(ovf[j])
    );
  end

  // The flags travel beside the dividers, one stage per quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 32; k++) sb_valid[k] <= 1'b0;
    end else if (en) begin
      sb_valid[0] <= side.valid;
      for (int k = 1; k < 32; k++) sb_valid[k] <= sb_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_flags[0] <= side.flags;
      for (int k = 1; k < 32; k++) sb_flags[k] <= sb_flags[k-1];
    end
  end

  cpm_flags_t  fl;
  logic [32:0] r_fit, r_oth, r_offp, r_offr, r_ds, r_dof;
  logic        lens_sat, depth_sat;

  always_comb begin
    fl        = sb_flags[31];
    r_fit     = sat_round(quo[0], ovf[0], 1'b0);
    r_oth     = sat_round(quo[1], ovf[1], 1'b0);
    r_offp    = sat_round(quo[2], ovf[2], fl.neg_p);
    r_offr    = sat_round(quo[3], ovf[3], fl.neg_r);
    r_ds      = sat_round(quo[4], ovf[4], fl.dneg);
    r_dof     = sat_round(quo[5], ovf[5], fl.dneg);
    lens_sat  = r_fit[32] || r_oth[32] || r_offp[32] || r_offr[32];
    depth_sat = r_ds[32] || r_dof[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= sb_valid[31];
    end
  end

  // Horizontal fit puts the fitted terms on x; vertical fit swaps the axes.
  always_ff @(posedge clk) begin
    if (en) begin
      if (fl.lens_err) begin
        x_scale <= '0;
        y_scale <= '0;
        x_shift <= '0;
        y_shift <= '0;
      end else if (fl.vert) begin
        x_scale <= r_oth[31:0];
        y_scale <= r_fit[31:0];
        x_shift <= r_offr[31:0];
        y_shift <= r_offp[31:0];
      end else begin
        x_scale <= r_fit[31:0];
        y_scale <= r_oth[31:0];
        x_shift <= r_offp[31:0];
        y_shift <= r_offr[31:0];
      end
      if (fl.depth_err) begin
        depth_scale  <= '0;
        depth_offset <= '0;
      end else begin
        depth_scale  <= r_ds[31:0];
        depth_offset <= r_dof[31:0];
      end
      math_error <= (fl.lens_err || lens_sat) || (fl.depth_err || depth_sat);
    end
  end

endmodule

// ===== tb/sv/tb_camera_projection_matrix_unit.sv =====
`timescale 1ns / 100ps

// A plain holder for one projection result: the six matrix entries and the error flag.
class proj_words;
  logic signed [31:0] xs, ys, xsh, ysh, ds, dof;
  logic               err;
endclass

// Scoreboard that holds the camera settings, predicts the projection words
// and compares them against what the block sends back.
class proj_scoreboard;
  localparam int FB = 16;

  logic [1:0]  fit;
  logic [14:0] rw, rh;
  logic [25:0] near_cm;
  logic [35:0] far_cm;
  logic [22:0] scale;

  proj_words pending_q[$];
  int        mismatches;

  function new();
    fit = cpm_pkg::FIT_HORIZ;
    rw = 128;
    rh = 128;
    near_cm = 6554;
    far_cm = 65536000;
    scale = 65536;
    mismatches = 0;
  endfunction

  // Round num/den to nearest, ties away from zero, negate and saturate.
  function logic [31:0] round_sat(logic [255:0] num, logic [255:0] den, bit neg,
                                  ref bit err);
    logic [255:0] q;
    q = ((num << 1) + den) / (den << 1);
    if (!neg) begin
      if (q > 256'h7FFFFFFF) begin
        err = 1;
        return 32'h7FFFFFFF;
      end
      return q[31:0];
    end
    if (q > 256'h80000000) begin
      err = 1;
      return 32'h80000000;
    end
    return 32'd0 - q[31:0];
  endfunction

  function void note_item(logic [25:0] f, logic [19:0] w, logic [19:0] h,
                          logic signed [20:0] ox, logic signed [20:0] oy);
    proj_words    p;
    bit           err, oxn, oyn, vert, wider, dneg;
    logic [255:0] one, base, cube, oxm, oym, diff;
    p = new();
    err = 0;
    one = 256'd1 << FB;
    oxn = ox[20];
    oyn = oy[20];
    oxm = oxn ? 256'(-ox) : 256'(ox);
    oym = oyn ? 256'(-oy) : 256'(oy);
    p.xs = 0; p.ys = 0; p.xsh = 0; p.ysh = 0; p.ds = 0; p.dof = 0;
    if (f != 0 && w != 0 && h != 0 && near_cm != 0 && scale != 0 && rw != 0 && rh != 0)
    begin
      base = 256'd127 * near_cm * scale;
      cube = 256'(f) * one * one * one;
      wider = 256'(w) * rh > 256'(rw) * h;
      vert = fit == cpm_pkg::FIT_VERT || (fit == cpm_pkg::FIT_FILL && wider) ||
             (fit == cpm_pkg::FIT_OVER && !wider);
      if (!vert) begin
        p.xs  = round_sat(cube, base * w, 0, err);
        p.ys  = round_sat(cube * rw, base * w * rh, 0, err);
        p.xsh = round_sat(2 * oxm * one, 256'(w), oxn, err);
        p.ysh = round_sat(2 * oym * rw * one, 256'(w) * rh, oyn, err);
      end else begin
        p.xs  = round_sat(cube * rh, base * h * rw, 0, err);
        p.ys  = round_sat(cube, base * h, 0, err);
        p.xsh = round_sat(2 * oxm * rh * one, 256'(h) * rw, oxn, err);
        p.ysh = round_sat(2 * oym * one, 256'(h), oyn, err);
      end
    end else begin
      err = 1;
    end
    if (far_cm != near_cm) begin
      dneg = far_cm < near_cm;
      diff = dneg ? 256'(near_cm) - far_cm : 256'(far_cm) - near_cm;
      p.ds  = round_sat((256'(far_cm) + near_cm) * one, diff, dneg, err);
      p.dof = round_sat(2 * 256'(far_cm) * near_cm, diff, dneg, err);
    end else begin
      err = 1;
    end
    p.err = err;
    pending_q.push_back(p);
  endfunction

  function void check_result(proj_words got);
    proj_words e;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result word at %0t", $time);
      return;
    end
    e = pending_q.pop_front();
    if (got.xs !== e.xs || got.ys !== e.ys || got.xsh !== e.xsh ||
        got.ysh !== e.ysh || got.ds !== e.ds || got.dof !== e.dof ||
        got.err !== e.err) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch at %0t: expected %0d %0d %0d %0d %0d %0d err %0d", $time,
                 e.xs, e.ys, e.xsh, e.ysh, e.ds, e.dof, e.err);
        $display("                 actual %0d %0d %0d %0d %0d %0d err %0d",
                 got.xs, got.ys, got.xsh, got.ysh, got.ds, got.dof, got.err);
      end
    end
  endfunction
endclass

module tb_camera_projection_matrix_unit;
  import cpm_pkg::*;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_FIT    = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_NEAR   = 3'd3;
  localparam logic [2:0] REG_FAR    = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;
  localparam logic [2:0] REG_SPARE  = 3'd7;

  // The block's latency, used for the quiet time before the run ends.
  localparam int LATENCY = 41;

  logic               clk = 0;
  logic               rst = 1;
  logic               item_valid = 0;
  logic               item_stall;
  logic [25:0]        focal_mm = 0;
  logic [19:0]        aperture_width = 0;
  logic [19:0]        aperture_height = 0;
  logic signed [20:0] offset_horizontal = 0;
  logic signed [20:0] offset_vertical = 0;
  logic               result_valid;
  logic               result_stall = 0;
  logic signed [31:0] x_scale, y_scale, x_shift, y_shift, depth_scale, depth_offset;
  logic               math_error;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 0;
  logic [35:0]        cfg_data = 0;

  proj_scoreboard sb = new();

  // Set when stimulus is done, so the receiver stops stalling at random.
  bit stim_done = 0;
  // Set by the stimulus process to request one long hold-off on the result side.
  bit long_hold = 0;

  camera_projection_matrix_unit u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Each accepted input word is predicted right away; accepted results are
  // checked in order. Both sides sample at the rising edge, before any
  // nonblocking update from the driving processes lands.
  always @(posedge clk) begin
    proj_words got;
    if (!rst && item_valid && !item_stall)
      sb.note_item(focal_mm, aperture_width, aperture_height,
                   offset_horizontal, offset_vertical);
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIT:    sb.fit = cfg_data[1:0];
        REG_WIDTH:  sb.rw = cfg_data[14:0];
        REG_HEIGHT: sb.rh = cfg_data[14:0];
        REG_NEAR:   sb.near_cm = cfg_data[25:0];
        REG_FAR:    sb.far_cm = cfg_data[35:0];
        REG_SCALE:  sb.scale = cfg_data[22:0];
        default: ;
      endcase
    end
    if (!rst && result_valid && !result_stall) begin
      got = new();
      got.xs = x_scale; got.ys = y_scale; got.xsh = x_shift; got.ysh = y_shift;
      got.ds = depth_scale; got.dof = depth_offset; got.err = math_error;
      sb.check_result(got);
    end
  end

  // Receiver stall pattern: runs of free flow, runs of random stalls and runs
  // of steady stalls. A long hold-off is taken once on request, counted here.
  initial begin
    int run, mode, i;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        result_stall <= 1;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      run = $urandom_range(1, 40);
      mode = stim_done ? 0 : $urandom_range(0, 2);
      for (i = 0; i < run; i++) begin
        case (mode)
          0: result_stall <= 0;
          1: result_stall <= ($urandom_range(0, 2) == 0);
          default: result_stall <= 1;
        endcase
        @(posedge clk);
      end
    end
  end

  // Configuration writes wait for ready; the caller keeps the block idle.
  // Valid drops for one cycle after each write.
  task automatic write_reg(logic [2:0] idx, logic [35:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_setting(logic [1:0] fm, logic [14:0] w, logic [14:0] h,
                               logic [25:0] n, logic [35:0] f, logic [22:0] s);
    write_reg(REG_FIT, 36'(fm));
    write_reg(REG_WIDTH, 36'(w));
    write_reg(REG_HEIGHT, 36'(h));
    write_reg(REG_NEAR, 36'(n));
    write_reg(REG_FAR, f);
    write_reg(REG_SCALE, 36'(s));
  endtask

  // Offer one input word and hold it until the block takes it. Valid stays
  // high from one word to the next, so there is no low pulse within a step.
  task automatic send_item(logic [25:0] f, logic [19:0] w, logic [19:0] h,
                           logic signed [20:0] ox, logic signed [20:0] oy);
    item_valid <= 1;
    focal_mm <= f;
    aperture_width <= w;
    aperture_height <= h;
    offset_horizontal <= ox;
    offset_vertical <= oy;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      item_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random lens values, mostly inside the documented ranges; now and then
  // the full field width is used so every bit toggles.
  task automatic send_random();
    logic [25:0]        f;
    logic [19:0]        w, h;
    logic signed [20:0] ox, oy;
    if ($urandom_range(0, 9) == 0) begin
      f = 26'($urandom);
      w = 20'($urandom);
      h = 20'($urandom);
      ox = 21'($urandom);
      oy = 21'($urandom);
    end else begin
      f = 26'($urandom_range(65536, 65536000));
      w = 20'($urandom_range(655, 655360));
      h = 20'($urandom_range(655, 655360));
      ox = $signed(21'($urandom_range(0, 1310720))) - 21'sd655360;
      oy = $signed(21'($urandom_range(0, 1310720))) - 21'sd655360;
    end
    send_item(f, w, h, ox, oy);
  endtask

  // Random bursts of words, each followed by a random idle gap three times out of four.
  task automatic random_phase(int n);
    int sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_random();
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);
  endtask

  // Wait for every expected word, then let the pipe run dry.
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, range extremes, zero inputs and saturation.
    send_item(26'd65536, 20'd655, 20'd655, -21'sd655360, 21'sd655360);
    send_item(26'd65536000, 20'd655360, 20'd655360, 21'sd655360, -21'sd655360);
    send_item(26'h3FFFFFF, 20'hFFFFF, 20'd1, 21'sd0, -21'sd1);
    send_item(26'd0, 20'd1000, 20'd1000, 21'sd5, 21'sd5);        // zero focal length
    send_item(26'd65536, 20'd0, 20'd1000, 21'sd5, 21'sd5);       // zero film width
    send_item(26'd65536, 20'd1000, 20'd0, 21'sd5, 21'sd5);       // zero film height
    send_item(26'd1, 20'd655360, 20'd655360, 21'sd0, 21'sd0);
    send_item(26'd65536000, 20'd1, 20'd1, 21'h0FFFFF, 21'h100000); // saturation
    idle_gap(1);
    drain();

    // Film narrower than the image, by a wide and by a slim margin, under each fit rule.
    for (int m = 0; m < 4; m++) begin
      write_setting(m[1:0], 15'd1920, 15'd1080, 26'd6554, 36'd65536000, 23'd65536);
      send_item(26'd3276800, 20'd94372, 20'd62915, 21'sd1000, -21'sd2000);
      send_item(26'd3276800, 20'd62915, 20'd94372, -21'sd3000, 21'sd4000);
      send_item(26'd3276800, 20'd117964, 20'd66355, 21'sd0, 21'sd0);
      idle_gap(1);
      drain();
    end

    // Zero render size and scale, equal planes, and near beyond far.
    write_setting(FIT_FILL, 15'd0, 15'd0, 26'd0, 36'd0, 23'd0);
    send_item(26'd65536, 20'd1000, 20'd1000, 21'sd1, 21'sd1);
    idle_gap(1);
    drain();
    write_setting(FIT_OVER, 15'd16384, 15'd1, 26'd65536000, 36'd65536, 23'd6553600);
    send_item(26'd65536000, 20'd655360, 20'd655, 21'sd655360, 21'sd655360);
    send_item(26'd65536, 20'd655, 20'd655360, -21'sd655360, -21'sd655360);
    idle_gap(1);
    drain();
    write_setting(FIT_VERT, 15'd1, 15'd16384, 26'h3FFFFFF, 36'hFFFFFFFFF, 23'h7FFFFF);
    write_reg(REG_SPARE, 36'hFFFFFFFFF);                    // index past the list
    send_item(26'd65536, 20'd655, 20'd655360, 21'sd3, -21'sd3);
    idle_gap(1);
    drain();

    // Random phases under assorted settings; extremes of the ranges included.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_setting(FIT_HORIZ, 15'd128, 15'd128, 26'd6554, 36'd65536000, 23'd65536);
        1: write_setting(FIT_FILL, 15'd1, 15'd1, 26'd66, 36'd65536, 23'd655);
        2: write_setting(FIT_OVER, 15'd16384, 15'd16384, 26'd65536000,
                         36'd65536000000, 23'd6553600);
        default: write_setting(2'($urandom_range(0, 3)), 15'($urandom_range(1, 16384)),
                               15'($urandom_range(1, 16384)),
                               26'($urandom_range(66, 65536000)),
                               {4'($urandom_range(0, 15)), 32'($urandom)},
                               23'($urandom_range(655, 6553600)));
      endcase
      if (ph == 4) begin
        // Hold the result side off while the sender keeps offering words.
        long_hold = 1;
        for (int i = 0; i < 120; i++) send_random();
        idle_gap(1);
      end
      random_phase(140);
      drain();
    end

    stim_done = 1;
    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cpm_pkg.sv
src/cpm_div.sv
src/cpm_front.sv
src/camera_projection_matrix_unit.sv
tb/sv/tb_camera_projection_matrix_unit.sv
